// ----- design/wrp_pkg.sv -----
`default_nettype none
package wrp_pkg;

    localparam int MAX_PEERS_DEF = 64;
    localparam int RANGE_W       = 14;
    localparam int TRY_W         = 5;

    localparam logic [TRY_W-1:0] TRY_LIMIT_RST = 5'd20;
    localparam logic [TRY_W-1:0] TRY_SAT       = 5'd31;
    localparam logic [31:0]      LFSR_TAPS     = 32'hA300_0000;
    localparam logic [31:0]      SEED_RST      = 32'd1;
    localparam logic [15:0]      CONNS_SAT     = 16'hFFFF;

    // item functions
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_PICK  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_ACK      = 2'd0;
    localparam logic [1:0] ST_PICKED   = 2'd1;
    localparam logic [1:0] ST_FALLBACK = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TWO_CHOICES = 2'd0;
    localparam logic [1:0] CFG_PEER_COUNT  = 2'd1;
    localparam logic [1:0] CFG_TRY_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_SEED        = 2'd3;

    // table read address select
    localparam logic [1:0] RD_PREV  = 2'd0;
    localparam logic [1:0] RD_MID   = 2'd1;
    localparam logic [1:0] RD_LO    = 2'd2;
    localparam logic [1:0] RD_FINAL = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  peer_index;
        logic [7:0]  peer_weight;
        logic        peer_down;
        logic [7:0]  peer_fail_limit;
        logic [7:0]  peer_fails;
        logic [15:0] peer_fail_timeout;
        logic [15:0] peer_conn_limit;
        logic [15:0] peer_conns;
        logic [31:0] peer_checked;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] picked_index;
    } t_out_item;

    typedef struct packed {
        logic [RANGE_W-1:0] range_start;
        logic [7:0]         weight;
        logic               down;
        logic [7:0]         fail_limit;
        logic [7:0]         fails;
        logic [15:0]        timeout;
        logic [15:0]        conn_limit;
        logic [15:0]        conns;
        logic [31:0]        checked;
    } t_entry;

    typedef struct packed {
        logic       accept;
        logic       clr_req;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       ld_wr;
        logic       step;
        logic       srch_init;
        logic       srch_upd;
        logic       hold_prev;
        logic       skip;
        logic       final_set;
        logic       final_prev;
        logic       fin_wr;
        logic       res_we;
        logic [1:0] res_code;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       load_oob;
        logic       pre_fb;
        logic       div_done;
        logic       srch_more;
        logic       cand_ok;
        logic       two_choices;
        logic       have_prev;
        logic       prev_wins;
        logic       skip_over;
        logic       out_busy;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- design/wrp_chan_if.sv -----
`default_nettype none
interface wrp_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/wrp_mod.sv -----
`default_nettype none
module wrp_mod
    import wrp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_dividend,
    input  wire logic [RANGE_W-1:0] i_divisor,
    output logic                    o_done,
    output logic [RANGE_W-1:0]      o_rem
);

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [31:0]        r_quo;
    logic [RANGE_W-1:0] r_rem;
    logic [RANGE_W-1:0] r_div;
    logic [RANGE_W:0]   trial;

    // restoring remainder, one dividend bit per cycle
    assign trial = {r_rem, r_quo[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= RANGE_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= RANGE_W'(trial);
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ----- design/wrp_dp.sv -----
`default_nettype none
module wrp_dp
    import wrp_pkg::*;
#(
    parameter int MAX_PEERS = MAX_PEERS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire t_in_item    i_item,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output t_out_item        o_out_item,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat
);

    localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CW = $clog2(MAX_PEERS + 1);

    // configuration
    logic             r_two;
    logic [6:0]       r_peer_count;
    logic [TRY_W-1:0] r_try_limit;

    // request state
    logic [31:0]          r_lfsr;
    logic [RANGE_W-1:0]   r_total;
    logic [MAX_PEERS-1:0] r_tried;
    logic [TRY_W-1:0]     r_try_cnt;

    t_in_item r_item;
    t_entry   r_mem [MAX_PEERS];
    t_entry   r_rd;

    logic [CW-1:0]      r_lo, r_hi;
    logic [RANGE_W-1:0] r_x;
    logic               r_have_prev;
    logic [IW-1:0]      r_prev;
    logic [15:0]        r_prev_c;
    logic [7:0]         r_prev_w;
    logic [IW-1:0]      r_final;
    logic [23:0]        r_p_cand, r_p_prev;
    logic [1:0]         r_res_status;
    logic [5:0]         r_res_idx;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CW-1:0]      act;
    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid;
    logic [IW-1:0]      cand;
    logic [IW-1:0]      raddr, waddr;
    t_entry             wdata, ld_entry, fin_entry;
    logic [RANGE_W-1:0] ld_start;
    logic [31:0]        n_lfsr;
    logic [TRY_W:0]     try_next;
    logic               fail_block, conn_block;
    logic               div_done;
    logic [RANGE_W-1:0] div_rem;
    logic [31:0]        seed_val;

    assign act = (32'(r_peer_count) > 32'(MAX_PEERS)) ? CW'(MAX_PEERS) : CW'(r_peer_count);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign cand    = IW'(r_lo);
    assign n_lfsr  = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);
    assign try_next = {1'b0, r_try_cnt} + {{TRY_W{1'b0}}, 1'b1};
    assign seed_val = (i_cfg_data == 32'd0) ? SEED_RST : i_cfg_data;

    assign fail_block = (r_rd.fail_limit != 8'd0) && (r_rd.fails >= r_rd.fail_limit)
                     && ((r_item.now - r_rd.checked) <= {16'd0, r_rd.timeout});
    assign conn_block = (r_rd.conn_limit != 16'd0) && (r_rd.conns >= r_rd.conn_limit);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV:  raddr = IW'(r_item.peer_index - 6'd1);
            RD_MID:   raddr = IW'(mid);
            RD_LO:    raddr = cand;
            RD_FINAL: raddr = r_final;
            default:  raddr = r_final;
        endcase
    end

    assign ld_start = r_item.peer_index == 6'd0 ? '0
                    : RANGE_W'(r_rd.range_start + RANGE_W'(r_rd.weight));

    always_comb begin
        ld_entry.range_start = ld_start;
        ld_entry.weight      = r_item.peer_weight;
        ld_entry.down        = r_item.peer_down;
        ld_entry.fail_limit  = r_item.peer_fail_limit;
        ld_entry.fails       = r_item.peer_fails;
        ld_entry.timeout     = r_item.peer_fail_timeout;
        ld_entry.conn_limit  = r_item.peer_conn_limit;
        ld_entry.conns       = r_item.peer_conns;
        ld_entry.checked     = r_item.peer_checked;

        fin_entry = r_rd;
        if ((r_item.now - r_rd.checked) > {16'd0, r_rd.timeout}) begin
            fin_entry.checked = r_item.now;
        end
        if (r_rd.conns != CONNS_SAT) begin
            fin_entry.conns = r_rd.conns + 16'd1;
        end
    end

    assign wdata = i_cmd.ld_wr ? ld_entry : fin_entry;
    assign waddr = i_cmd.ld_wr ? IW'(r_item.peer_index) : r_final;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr || i_cmd.fin_wr) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[raddr];
        end
    end

    wrp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.step),
        .i_dividend (n_lfsr),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two        <= 1'b0;
            r_peer_count <= '0;
            r_try_limit  <= TRY_LIMIT_RST;
            r_lfsr       <= SEED_RST;
            r_total      <= '0;
            r_tried      <= '0;
            r_try_cnt    <= '0;
            r_have_prev  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TWO_CHOICES: r_two        <= i_cfg_data[0];
                    CFG_PEER_COUNT:  r_peer_count <= i_cfg_data[6:0];
                    CFG_TRY_LIMIT:   r_try_limit  <= i_cfg_data[TRY_W-1:0];
                    CFG_SEED:        r_lfsr       <= seed_val;
                    default: ;
                endcase
            end
            if (i_cmd.step) begin
                r_lfsr <= n_lfsr;
            end
            if (i_cmd.ld_wr) begin
                r_total <= RANGE_W'(ld_start + RANGE_W'(r_item.peer_weight));
            end
            if (i_cmd.clr_req) begin
                r_tried   <= '0;
                r_try_cnt <= '0;
            end
            if (i_cmd.skip) begin
                r_try_cnt <= try_next[TRY_W] ? TRY_SAT : try_next[TRY_W-1:0];
            end
            if (i_cmd.fin_wr) begin
                r_tried[r_final] <= 1'b1;
            end
            if (i_cmd.accept) begin
                r_have_prev <= 1'b0;
            end else if (i_cmd.hold_prev) begin
                r_have_prev <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= act;
            r_x  <= div_rem;
        end else if (i_cmd.srch_upd) begin
            if (r_x < r_rd.range_start) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid;
            end
        end
        if (i_cmd.hold_prev) begin
            r_prev   <= cand;
            r_prev_c <= r_rd.conns;
            r_prev_w <= r_rd.weight;
        end
        r_p_cand <= r_rd.conns * r_prev_w;
        r_p_prev <= r_prev_c * r_rd.weight;
        if (i_cmd.final_set) begin
            r_final <= i_cmd.final_prev ? r_prev : cand;
        end
        if (i_cmd.res_we) begin
            r_res_status <= i_cmd.res_code;
            r_res_idx    <= (i_cmd.res_code == ST_PICKED) ? 6'(r_final) : 6'd0;
        end
        if (i_cmd.out_load) begin
            r_out.status       <= r_res_status;
            r_out.picked_index <= r_res_idx;
        end
    end

    always_comb begin
        o_stat.func        = r_item.func;
        o_stat.load_oob    = 32'(r_item.peer_index) >= 32'(MAX_PEERS);
        o_stat.pre_fb      = (r_try_cnt > r_try_limit) || (32'(act) < 2) || (r_total == '0);
        o_stat.div_done    = div_done;
        o_stat.srch_more   = (r_hi - r_lo) > CW'(1);
        o_stat.cand_ok     = !(r_have_prev && (cand == r_prev)) && !r_tried[cand]
                          && !r_rd.down && !fail_block && !conn_block;
        o_stat.two_choices = r_two;
        o_stat.have_prev   = r_have_prev;
        o_stat.prev_wins   = r_p_cand > r_p_prev;
        o_stat.skip_over   = try_next > {1'b0, r_try_limit};
        o_stat.out_busy    = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ----- design/wrp_ctrl.sv -----
`default_nettype none
module wrp_ctrl
    import wrp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_LD_WR   = 4'd2;
    localparam logic [3:0] S_PK_DIV  = 4'd3;
    localparam logic [3:0] S_SR_RD   = 4'd4;
    localparam logic [3:0] S_SR_CMP  = 4'd5;
    localparam logic [3:0] S_CD_CHK  = 4'd6;
    localparam logic [3:0] S_CD_MUL  = 4'd7;
    localparam logic [3:0] S_FIN_RD  = 4'd8;
    localparam logic [3:0] S_FIN_WR  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.res_we   = 1'b1;
                o_cmd.res_code = ST_ACK;
                n_state        = S_DONE;
                case (i_stat.func)
                    FUNC_LOAD: begin
                        if (!i_stat.load_oob) begin
                            // fetch the previous entry to extend the prefix sum
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_PREV;
                            n_state      = S_LD_WR;
                        end
                    end
                    FUNC_START: begin
                        o_cmd.clr_req = 1'b1;
                    end
                    FUNC_PICK: begin
                        if (i_stat.pre_fb) begin
                            o_cmd.res_code = ST_FALLBACK;
                        end else begin
                            o_cmd.step = 1'b1;
                            n_state    = S_PK_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            S_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                n_state     = S_DONE;
            end
            S_PK_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.srch_init = 1'b1;
                    n_state         = S_SR_RD;
                end
            end
            S_SR_RD: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.srch_more) begin
                    o_cmd.rd_sel = RD_MID;
                    n_state      = S_SR_CMP;
                end else begin
                    o_cmd.rd_sel = RD_LO;
                    n_state      = S_CD_CHK;
                end
            end
            S_SR_CMP: begin
                o_cmd.srch_upd = 1'b1;
                n_state        = S_SR_RD;
            end
            S_CD_CHK: begin
                if (i_stat.cand_ok && !i_stat.two_choices) begin
                    o_cmd.final_set = 1'b1;
                    n_state         = S_FIN_RD;
                end else if (i_stat.cand_ok && i_stat.have_prev) begin
                    n_state = S_CD_MUL;
                end else begin
                    // first valid candidate is held but still counts as a skip
                    o_cmd.hold_prev = i_stat.cand_ok;
                    o_cmd.skip      = 1'b1;
                    if (i_stat.skip_over) begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_code = ST_FALLBACK;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_PK_DIV;
                    end
                end
            end
            S_CD_MUL: begin
                o_cmd.final_set  = 1'b1;
                o_cmd.final_prev = i_stat.prev_wins;
                n_state          = S_FIN_RD;
            end
            S_FIN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_FINAL;
                n_state      = S_FIN_WR;
            end
            S_FIN_WR: begin
                o_cmd.fin_wr   = 1'b1;
                o_cmd.res_we   = 1'b1;
                o_cmd.res_code = ST_PICKED;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_busy)
        else $error("result loaded over a pending transfer");

    a_fin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN_WR) |-> ($past(r_state) == S_FIN_RD))
        else $error("writeback without entry read");

    a_chk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CD_CHK) |-> ($past(r_state) == S_SR_RD))
        else $error("candidate check without entry read");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_DEC))
        else $error("accepted item not decoded");

endmodule
`default_nettype wire

// ----- design/weighted_random_peer_selector.sv -----
`default_nettype none
// Weighted random peer selector. Load items (func 0) write one in-range peer
// entry and extend the prefix sum of weights; start items (func 1) clear the
// tried set and try count; pick items (func 2) draw candidates from a 32-bit
// LFSR reduced modulo the total weight and binary-searched over the ranges,
// skipping unusable peers, optionally keeping the less loaded of two. Every
// item returns one result. One item is worked at a time. A pick runs, for each
// of N drawn candidates (at most try_limit + 1), a bit-serial 32-step modulo
// unit, then one registered table read per search step, with a further
// weighing state in two-choice mode. A new item is taken while the previous
// result waits on the output.
module weighted_random_peer_selector
    import wrp_pkg::*;
#(
    parameter int MAX_PEERS = MAX_PEERS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    wrp_chan_if.sink         i_in,
    wrp_chan_if.source       o_out
);

    t_dp_cmd   cmd;
    t_dp_stat  stat;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    wrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wrp_dp #(
        .MAX_PEERS (MAX_PEERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in.payload),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_item;

endmodule
`default_nettype wire
